[src/ffba_pkg.sv]
// Shared types and constants for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

   localparam int POOL_UNITS_DEFAULT = 256;
   localparam int POOL_RESET         = 150;
   localparam int REQ_SIZE_W         = 9;
   localparam int START_W            = 8;
   localparam int POOL_REG_W         = 9;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_NO_MATCH = 2'd2,
      STATUS_ZERO     = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  op;
      logic [REQ_SIZE_W-1:0]   request_size;
      logic [START_W-1:0]      free_start;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [START_W-1:0]      block_address;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_NEXT,
      RD_LAST,
      RD_PREV
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_INIT,
      WR_FREE,
      WR_TAKE,
      WR_MOVE,
      WR_REST
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_ONE,
      CNT_INC
   } cnt_op_type;

   typedef enum logic [1:0] {
      ADDR_ZERO,
      ADDR_LOOK,
      ADDR_HIT
   } addr_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         pool_load;
      logic         req_load;
      logic         rd_en;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      cnt_op_type   cnt_op;
      logic         hit_load;
      logic         rsp_load;
      status_type   rsp_status;
      addr_src_type addr_src;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic   zero_req;
      op_type op;
      logic   hit;
      logic   split;
      logic   last;
      logic   moved;
   } stat_type;

endpackage

`default_nettype wire

[src/ffba_datapath.sv]
// Block table memory, scan pointer, item and result registers of the allocator.
`default_nettype none

module ffba_datapath #(
   parameter int POOL_UNITS = ffba_pkg::POOL_UNITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ffba_pkg::cmd_type                 cmd,
   output ffba_pkg::stat_type                stat,
   input  ffba_pkg::req_type                 req_data,
   input  logic [ffba_pkg::POOL_REG_W-1:0]   csr_data,
   output ffba_pkg::rsp_type                 rsp_data
);
   import ffba_pkg::*;

   localparam int SW = $clog2(POOL_UNITS + 1);
   localparam int AW = $clog2(POOL_UNITS);
   localparam int CW = (SW > REQ_SIZE_W) ? SW : REQ_SIZE_W;
   localparam int MW = (AW > START_W) ? AW : START_W;
   localparam int POOL_INIT = (POOL_RESET > POOL_UNITS) ? POOL_UNITS : POOL_RESET;

   typedef struct packed {
      logic          used;
      logic [SW-1:0] size;
      logic [AW-1:0] start;
   } entry_type;

   entry_type     entry_ff [POOL_UNITS];
   entry_type     rdata_ff;
   entry_type     hit_ff;
   entry_type     wr_data;
   logic [AW-1:0] look_ff;
   logic [AW-1:0] hit_idx_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic [SW-1:0] count_ff, count_in;
   logic [SW-1:0] pool_size_ff, pool_size_in;
   req_type       req_ff;
   rsp_type       rsp_ff, rsp_in;
   logic [CW-1:0] req_cw;
   logic [CW-1:0] size_cw;
   logic          fits;
   logic          match;

   // Table scan checks on the entry just read.
   assign req_cw  = CW'(req_ff.request_size);
   assign size_cw = CW'(rdata_ff.size);
   assign fits    = !rdata_ff.used && (size_cw >= req_cw);
   assign match   = rdata_ff.used && (MW'(rdata_ff.start) == MW'(req_ff.free_start));

   always_comb begin
      stat.zero_req = (req_data.op == OP_ALLOC) && (req_data.request_size == '0);
      stat.op       = req_ff.op;
      stat.hit      = (req_ff.op == OP_ALLOC) ? fits : match;
      stat.split    = (size_cw > req_cw) && (count_ff != SW'(POOL_UNITS));
      stat.last     = ((SW'(look_ff) + SW'(1)) == count_ff);
      stat.moved    = (look_ff == (hit_idx_ff + AW'(1)));
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_ZERO: rd_addr = '0;
         RD_NEXT: rd_addr = look_ff + AW'(1);
         RD_LAST: rd_addr = AW'(count_ff - SW'(1));
         RD_PREV: rd_addr = look_ff - AW'(1);
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = look_ff;
      wr_data = rdata_ff;
      case (cmd.wr_sel)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_INIT: begin
            wr_addr       = '0;
            wr_data.used  = 1'b0;
            wr_data.size  = pool_size_ff;
            wr_data.start = '0;
         end
         WR_FREE: begin
            wr_data.used = 1'b0;
         end
         WR_TAKE: begin
            wr_data.used = 1'b1;
            if (stat.split) begin
               wr_data.size = SW'(req_ff.request_size);
            end
         end
         WR_MOVE: begin
            wr_addr = look_ff + AW'(1);
         end
         WR_REST: begin
            wr_addr       = hit_idx_ff + AW'(1);
            wr_data.used  = 1'b0;
            wr_data.size  = hit_ff.size - SW'(req_ff.request_size);
            wr_data.start = hit_ff.start + AW'(req_ff.request_size);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Block table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= entry_ff[rd_addr];
         look_ff  <= rd_addr;
      end
   end

   always_comb begin
      if (csr_data == '0) begin
         pool_size_in = SW'(1);
      end else if (CW'(csr_data) > CW'(POOL_UNITS)) begin
         pool_size_in = SW'(POOL_UNITS);
      end else begin
         pool_size_in = SW'(csr_data);
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_ONE:  count_in = SW'(1);
         CNT_INC:  count_in = count_ff + SW'(1);
         default:  count_in = count_ff;
      endcase
   end

   always_comb begin
      rsp_in.status = cmd.rsp_status;
      case (cmd.addr_src)
         ADDR_ZERO: rsp_in.block_address = '0;
         ADDR_LOOK: rsp_in.block_address = START_W'(rdata_ff.start);
         ADDR_HIT:  rsp_in.block_address = START_W'(hit_ff.start);
         default:   rsp_in.block_address = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= SW'(POOL_INIT);
         count_ff     <= SW'(1);
      end else begin
         if (cmd.pool_load) begin
            pool_size_ff <= pool_size_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      if (cmd.hit_load) begin
         hit_ff     <= rdata_ff;
         hit_idx_ff <= look_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[src/ffba_ctrl.sv]
// Sequencer of the allocator: table init, scan, entry shift and result strobe.
`default_nettype none

module ffba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                csr_valid,
   input  ffba_pkg::stat_type  stat,
   output ffba_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                csr_ready,
   output logic                rsp_valid
);
   import ffba_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_REST
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = 1'b0;
      cmd.pool_load  = 1'b0;
      cmd.req_load   = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_sel     = RD_ZERO;
      cmd.wr_sel     = WR_NONE;
      cmd.cnt_op     = CNT_HOLD;
      cmd.hit_load   = 1'b0;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = STATUS_OK;
      cmd.addr_src   = ADDR_ZERO;
      case (state_ff)
         ST_INIT: begin
            cmd.wr_sel = WR_INIT;
            cmd.cnt_op = CNT_ONE;
            state_in   = ST_IDLE;
         end
         ST_IDLE: begin
            // An offered item wins; a pool write waits until start drops.
            if (start) begin
               cmd.req_load = 1'b1;
               if (stat.zero_req) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = STATUS_ZERO;
                  rsp_valid_in   = 1'b1;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ZERO;
                  state_in   = ST_SCAN;
               end
            end else if (csr_valid) begin
               cmd.pool_load = 1'b1;
               state_in      = ST_INIT;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               if (stat.op == OP_FREE) begin
                  cmd.wr_sel   = WR_FREE;
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else if (!stat.split) begin
                  cmd.wr_sel   = WR_TAKE;
                  cmd.rsp_load = 1'b1;
                  cmd.addr_src = ADDR_LOOK;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.wr_sel   = WR_TAKE;
                  cmd.hit_load = 1'b1;
                  if (stat.last) begin
                     state_in = ST_REST;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = ST_SHIFT;
                  end
               end
            end else if (stat.last) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = (stat.op == OP_FREE) ? STATUS_NO_MATCH : STATUS_NO_FIT;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end
         ST_SHIFT: begin
            cmd.wr_sel = WR_MOVE;
            if (stat.moved) begin
               state_in = ST_REST;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
            end
         end
         ST_REST: begin
            cmd.wr_sel   = WR_REST;
            cmd.cnt_op   = CNT_INC;
            cmd.rsp_load = 1'b1;
            cmd.addr_src = ADDR_HIT;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: controller plus table datapath.
// A zero-size allocate ends in the cycle after acceptance; else the scan reads table entries
// in order from entry 0 until a hit or a miss over all n entries, and a needed split then
// shifts the entries after the hit up by one, last first, and writes the remainder entry.
// One item at a time: a new item is taken only in idle, after the table walk ends.
// Receiver cannot stall: each result is a 1-cycle strobe. Synchronous reset, then the init state.
`default_nettype none

module first_fit_block_allocator #(
   parameter int POOL_UNITS = ffba_pkg::POOL_UNITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel: item taken when start is high and busy is low
   input  logic                              start,
   output logic                              busy,
   input  ffba_pkg::req_type                 req_data,
   // Result channel: one-cycle strobe, no back pressure
   output logic                              rsp_valid,
   output ffba_pkg::rsp_type                 rsp_data,
   // Pool size register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffba_pkg::POOL_REG_W-1:0]   csr_data
);
   import ffba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Controller: decide each cycle which table access and result update to run.
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid)
   );

   // Datapath: hold the block table, the scan pointer and the result register.
   ffba_datapath #(
      .POOL_UNITS (POOL_UNITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
